// ===== src/amel_pkg.sv =====
// Shared types, constants and helper functions of the angular map lookup.
`default_nettype none

package amel_pkg;

    // Map and field sizes.
    localparam int MAX_SIDE     = 256;
    localparam int SIDE_BITS    = $clog2(MAX_SIDE + 1);
    localparam int COORD_BITS   = $clog2(MAX_SIDE);
    localparam int CHANNEL_BITS = 16;
    localparam int DIR_BITS     = 16;
    localparam int ADDR_BITS    = 16;
    localparam int MAG_BITS     = DIR_BITS + 1;
    localparam int TEXEL_BITS   = 3 * CHANNEL_BITS;
    localparam int STORE_DEPTH  = 1 << ADDR_BITS;

    // Arithmetic depth of the pipelined units.
    localparam int SQRT_STEPS   = 32;
    localparam int CORDIC_STEPS = 30;
    localparam int DIV_STEPS    = 32;
    localparam int CW           = 36;
    localparam int AW           = 34;

    // Configuration register indexes.
    localparam logic REG_MAP_WIDTH  = 1'b0;
    localparam logic REG_MAP_HEIGHT = 1'b1;

    typedef enum logic
    {
        OP_WRITE  = 1'b0,
        OP_LOOKUP = 1'b1
    } op_t;

    // One accepted input word, minus the direction.
    typedef struct packed
    {
        op_t                     opcode;
        logic [ADDR_BITS-1:0]    addr;
        logic [CHANNEL_BITS-1:0] red;
        logic [CHANNEL_BITS-1:0] green;
        logic [CHANNEL_BITS-1:0] blue;
    } item_t;

    // Normalized direction magnitudes and signs.
    typedef struct packed
    {
        logic        nx;
        logic        ny;
        logic        nz;
        logic        zero;
        logic [31:0] ax;
        logic [31:0] ay;
        logic [31:0] az;
    } dir_t;

    // Word handed from the coordinate pipeline to the texel store.
    typedef struct packed
    {
        logic                  valid;
        item_t                 item;
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;
        logic [ADDR_BITS-1:0]  index;
    } coord_t;

    // Arctangent of 2^-i in units of 2^-32 turn.
    function automatic logic signed [AW-1:0] turn_atan(input int i);
        logic signed [AW-1:0] a;
        case (i)
            0:  a = 34'sd536870912;
            1:  a = 34'sd316933406;
            2:  a = 34'sd167458907;
            3:  a = 34'sd85004756;
            4:  a = 34'sd42667331;
            5:  a = 34'sd21354465;
            6:  a = 34'sd10679838;
            7:  a = 34'sd5340245;
            8:  a = 34'sd2670163;
            9:  a = 34'sd1335087;
            10: a = 34'sd667544;
            11: a = 34'sd333772;
            12: a = 34'sd166886;
            13: a = 34'sd83443;
            14: a = 34'sd41722;
            15: a = 34'sd20861;
            16: a = 34'sd10430;
            17: a = 34'sd5215;
            18: a = 34'sd2608;
            19: a = 34'sd1304;
            20: a = 34'sd652;
            21: a = 34'sd326;
            22: a = 34'sd163;
            23: a = 34'sd81;
            24: a = 34'sd41;
            25: a = 34'sd20;
            26: a = 34'sd10;
            27: a = 34'sd5;
            28: a = 34'sd3;
            29: a = 34'sd1;
            default: a = '0;
        endcase
        return a;
    endfunction

    // Map side in use: a zero register means one, large values saturate.
    function automatic logic [SIDE_BITS-1:0] side_of(input logic [SIDE_BITS-1:0] r);
        logic [SIDE_BITS-1:0] s;
        if (r == '0)
            s = SIDE_BITS'(1);
        else if (r > SIDE_BITS'(MAX_SIDE))
            s = SIDE_BITS'(MAX_SIDE);
        else
            s = r;
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== src/amel_coord.sv =====
// Pipeline that turns a direction into a map column, row and texel index.
`default_nettype none

module amel_coord
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    input  wire amel_pkg::item_t                    in_item,
    input  wire logic [amel_pkg::DIR_BITS-1:0]      dir_x,
    input  wire logic [amel_pkg::DIR_BITS-1:0]      dir_y,
    input  wire logic [amel_pkg::DIR_BITS-1:0]      dir_z,
    input  wire logic [amel_pkg::SIDE_BITS-1:0]     side_w,
    input  wire logic [amel_pkg::SIDE_BITS-1:0]     side_h,
    output amel_pkg::coord_t                        out_word
);
    import amel_pkg::*;

    // Stage 1: magnitudes and signs.
    logic                v1_reg;
    item_t               it1_reg;
    logic [MAG_BITS-1:0] mx1_reg, my1_reg, mz1_reg;
    logic                nx1_reg, ny1_reg, nz1_reg;

    function automatic logic [MAG_BITS-1:0] mag_of(input logic [DIR_BITS-1:0] raw);
        logic [MAG_BITS-1:0] full;
        full = {1'b0, raw};
        return raw[DIR_BITS-1] ? ((MAG_BITS'(1) << DIR_BITS) - full) : full;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        it1_reg <= in_item;
        mx1_reg <= mag_of(dir_x);
        my1_reg <= mag_of(dir_y);
        mz1_reg <= mag_of(dir_z);
        nx1_reg <= dir_x[DIR_BITS-1];
        ny1_reg <= dir_y[DIR_BITS-1];
        nz1_reg <= dir_z[DIR_BITS-1];
    end

    // Stage 2: shift count that brings the largest magnitude to [2^30, 2^31).
    logic [MAG_BITS-1:0] m_max;
    logic [4:0]          msb;
    logic                v2_reg;
    item_t               it2_reg;
    dir_t                d2_reg;
    logic [4:0]          sh2_reg;

    always_comb
    begin
        m_max = (mx1_reg > my1_reg) ? mx1_reg : my1_reg;
        if (mz1_reg > m_max)
            m_max = mz1_reg;
        msb = '0;
        for (int i = 0; i < MAG_BITS; i++)
        begin
            if (m_max[i])
                msb = 5'(i);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        it2_reg      <= it1_reg;
        sh2_reg      <= 5'd30 - msb;
        d2_reg.nx    <= nx1_reg;
        d2_reg.ny    <= ny1_reg;
        d2_reg.nz    <= nz1_reg;
        d2_reg.zero  <= (mx1_reg == '0) && (my1_reg == '0);
        d2_reg.ax    <= 32'(mx1_reg);
        d2_reg.ay    <= 32'(my1_reg);
        d2_reg.az    <= 32'(mz1_reg);
    end

    // Stage 3: normalizing shift.
    logic  v3_reg;
    item_t it3_reg;
    dir_t  d3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        it3_reg     <= it2_reg;
        d3_reg.nx   <= d2_reg.nx;
        d3_reg.ny   <= d2_reg.ny;
        d3_reg.nz   <= d2_reg.nz;
        d3_reg.zero <= d2_reg.zero;
        d3_reg.ax   <= d2_reg.ax << sh2_reg;
        d3_reg.ay   <= d2_reg.ay << sh2_reg;
        d3_reg.az   <= d2_reg.az << sh2_reg;
    end

    // Stage 4: squares.
    logic        v4_reg;
    item_t       it4_reg;
    dir_t        d4_reg;
    logic [63:0] sqx4_reg, sqy4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        it4_reg  <= it3_reg;
        d4_reg   <= d3_reg;
        sqx4_reg <= 64'(d3_reg.ax) * 64'(d3_reg.ax);
        sqy4_reg <= 64'(d3_reg.ay) * 64'(d3_reg.ay);
    end

    // Square root, one result bit per stage; entry 0 holds the radicand.
    logic        sq_v_reg   [0:SQRT_STEPS];
    item_t       sq_it_reg  [0:SQRT_STEPS];
    dir_t        sq_d_reg   [0:SQRT_STEPS];
    logic [63:0] sq_n_reg   [0:SQRT_STEPS];
    logic [63:0] sq_res_reg [0:SQRT_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_v_reg[0] <= 1'b0;
        else
            sq_v_reg[0] <= v4_reg;
    end

    always_ff @(posedge clk)
    begin
        sq_it_reg[0]  <= it4_reg;
        sq_d_reg[0]   <= d4_reg;
        sq_n_reg[0]   <= sqx4_reg + sqy4_reg;
        sq_res_reg[0] <= '0;
    end

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] trial;

        assign trial = sq_res_reg[k] + BIT;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_v_reg[k+1] <= 1'b0;
            else
                sq_v_reg[k+1] <= sq_v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            sq_it_reg[k+1] <= sq_it_reg[k];
            sq_d_reg[k+1]  <= sq_d_reg[k];
            if (sq_n_reg[k] >= trial)
            begin
                sq_n_reg[k+1]   <= sq_n_reg[k] - trial;
                sq_res_reg[k+1] <= (sq_res_reg[k] >> 1) + BIT;
            end
            else
            begin
                sq_n_reg[k+1]   <= sq_n_reg[k];
                sq_res_reg[k+1] <= sq_res_reg[k] >> 1;
            end
        end
    end

    // CORDIC vectoring of (|z|, rho), one micro-rotation per stage.
    logic                 co_v_reg   [0:CORDIC_STEPS];
    item_t                co_it_reg  [0:CORDIC_STEPS];
    dir_t                 co_d_reg   [0:CORDIC_STEPS];
    logic [31:0]          co_rho_reg [0:CORDIC_STEPS];
    logic signed [CW-1:0] co_px_reg  [0:CORDIC_STEPS];
    logic signed [CW-1:0] co_py_reg  [0:CORDIC_STEPS];
    logic signed [AW-1:0] co_acc_reg [0:CORDIC_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            co_v_reg[0] <= 1'b0;
        else
            co_v_reg[0] <= sq_v_reg[SQRT_STEPS];
    end

    always_ff @(posedge clk)
    begin
        co_it_reg[0]  <= sq_it_reg[SQRT_STEPS];
        co_d_reg[0]   <= sq_d_reg[SQRT_STEPS];
        co_rho_reg[0] <= sq_res_reg[SQRT_STEPS][31:0];
        co_px_reg[0]  <= CW'(sq_d_reg[SQRT_STEPS].az);
        co_py_reg[0]  <= CW'(sq_res_reg[SQRT_STEPS][31:0]);
        co_acc_reg[0] <= '0;
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        localparam logic signed [AW-1:0] ANG = turn_atan(i);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                co_v_reg[i+1] <= 1'b0;
            else
                co_v_reg[i+1] <= co_v_reg[i];
        end

        always_ff @(posedge clk)
        begin
            co_it_reg[i+1]  <= co_it_reg[i];
            co_d_reg[i+1]   <= co_d_reg[i];
            co_rho_reg[i+1] <= co_rho_reg[i];
            if (!co_py_reg[i][CW-1])
            begin
                co_px_reg[i+1]  <= co_px_reg[i] + (co_py_reg[i] >>> i);
                co_py_reg[i+1]  <= co_py_reg[i] - (co_px_reg[i] >>> i);
                co_acc_reg[i+1] <= co_acc_reg[i] + ANG;
            end
            else
            begin
                co_px_reg[i+1]  <= co_px_reg[i] - (co_py_reg[i] >>> i);
                co_py_reg[i+1]  <= co_py_reg[i] + (co_px_reg[i] >>> i);
                co_acc_reg[i+1] <= co_acc_reg[i] - ANG;
            end
        end
    end

    // Clamp the angle to a quarter turn and fold in the sign of z.
    localparam logic signed [AW-1:0] QUARTER = AW'(64'd1 << 30);
    logic signed [AW-1:0] acc_last;
    logic [31:0]          t_clamp;
    logic                 ta_v_reg;
    item_t                ta_it_reg;
    dir_t                 ta_d_reg;
    logic [31:0]          ta_rho_reg;
    logic [31:0]          ta_t_reg;

    always_comb
    begin
        acc_last = co_acc_reg[CORDIC_STEPS];
        if (acc_last < 0)
            t_clamp = '0;
        else if (acc_last > QUARTER)
            t_clamp = 32'(QUARTER);
        else
            t_clamp = acc_last[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ta_v_reg <= 1'b0;
        else
            ta_v_reg <= co_v_reg[CORDIC_STEPS];
    end

    always_ff @(posedge clk)
    begin
        ta_it_reg  <= co_it_reg[CORDIC_STEPS];
        ta_d_reg   <= co_d_reg[CORDIC_STEPS];
        ta_rho_reg <= co_rho_reg[CORDIC_STEPS];
        ta_t_reg   <= co_d_reg[CORDIC_STEPS].nz ? (32'h8000_0000 - t_clamp) : t_clamp;
    end

    // Scale both magnitudes by the angle.
    logic        mu_v_reg;
    item_t       mu_it_reg;
    dir_t        mu_d_reg;
    logic [31:0] mu_rho_reg;
    logic [63:0] mu_pu_reg, mu_pv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mu_v_reg <= 1'b0;
        else
            mu_v_reg <= ta_v_reg;
    end

    always_ff @(posedge clk)
    begin
        mu_it_reg  <= ta_it_reg;
        mu_d_reg   <= ta_d_reg;
        mu_rho_reg <= ta_rho_reg;
        mu_pu_reg  <= 64'(ta_d_reg.ax) * 64'(ta_t_reg);
        mu_pv_reg  <= 64'(ta_d_reg.ay) * 64'(ta_t_reg);
    end

    // Restoring division of both products by rho, one quotient bit per stage.
    // The quotient never exceeds 32 bits since each magnitude is at most rho.
    logic        dv_v_reg   [0:DIV_STEPS];
    item_t       dv_it_reg  [0:DIV_STEPS];
    dir_t        dv_d_reg   [0:DIV_STEPS];
    logic [31:0] dv_rho_reg [0:DIV_STEPS];
    logic [31:0] dv_ru_reg  [0:DIV_STEPS];
    logic [31:0] dv_qu_reg  [0:DIV_STEPS];
    logic [31:0] dv_rv_reg  [0:DIV_STEPS];
    logic [31:0] dv_qv_reg  [0:DIV_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_v_reg[0] <= 1'b0;
        else
            dv_v_reg[0] <= mu_v_reg;
    end

    always_ff @(posedge clk)
    begin
        dv_it_reg[0]  <= mu_it_reg;
        dv_d_reg[0]   <= mu_d_reg;
        dv_rho_reg[0] <= mu_rho_reg;
        dv_ru_reg[0]  <= mu_pu_reg[63:32];
        dv_qu_reg[0]  <= mu_pu_reg[31:0];
        dv_rv_reg[0]  <= mu_pv_reg[63:32];
        dv_qv_reg[0]  <= mu_pv_reg[31:0];
    end

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        logic [32:0] sh_u, sh_v;
        logic        ge_u, ge_v;

        assign sh_u = {dv_ru_reg[k], dv_qu_reg[k][31]};
        assign sh_v = {dv_rv_reg[k], dv_qv_reg[k][31]};
        assign ge_u = sh_u >= {1'b0, dv_rho_reg[k]};
        assign ge_v = sh_v >= {1'b0, dv_rho_reg[k]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_v_reg[k+1] <= 1'b0;
            else
                dv_v_reg[k+1] <= dv_v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            dv_it_reg[k+1]  <= dv_it_reg[k];
            dv_d_reg[k+1]   <= dv_d_reg[k];
            dv_rho_reg[k+1] <= dv_rho_reg[k];
            dv_ru_reg[k+1]  <= ge_u ? 32'(sh_u - {1'b0, dv_rho_reg[k]}) : sh_u[31:0];
            dv_rv_reg[k+1]  <= ge_v ? 32'(sh_v - {1'b0, dv_rho_reg[k]}) : sh_v[31:0];
            dv_qu_reg[k+1]  <= {dv_qu_reg[k][30:0], ge_u};
            dv_qv_reg[k+1]  <= {dv_qv_reg[k][30:0], ge_v};
        end
    end

    // Offsets from the map centre; a direction along z reads the centre.
    logic [31:0] du, dv;
    logic        ce_v_reg;
    item_t       ce_it_reg;
    logic [32:0] ce_qu_reg, ce_qv_reg;

    assign du = dv_d_reg[DIV_STEPS].zero ? '0 : dv_qu_reg[DIV_STEPS];
    assign dv = dv_d_reg[DIV_STEPS].zero ? '0 : dv_qv_reg[DIV_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ce_v_reg <= 1'b0;
        else
            ce_v_reg <= dv_v_reg[DIV_STEPS];
    end

    always_ff @(posedge clk)
    begin
        ce_it_reg <= dv_it_reg[DIV_STEPS];
        ce_qu_reg <= dv_d_reg[DIV_STEPS].nx ? (33'h0_8000_0000 - 33'(du))
                                            : (33'h0_8000_0000 + 33'(du));
        ce_qv_reg <= dv_d_reg[DIV_STEPS].ny ? (33'h0_8000_0000 + 33'(dv))
                                            : (33'h0_8000_0000 - 33'(dv));
    end

    // Scale to the map sides and clamp to the last column and row.
    localparam int PW = 33 + SIDE_BITS;
    logic [PW-1:0]        pc, pr;
    logic [PW-33:0]       ic, ir;
    logic [SIDE_BITS-1:0] lim_w, lim_h;
    logic                 sc_v_reg;
    item_t                sc_it_reg;
    logic [COORD_BITS-1:0] sc_col_reg, sc_row_reg;

    always_comb
    begin
        pc    = PW'(ce_qu_reg) * PW'(side_w);
        pr    = PW'(ce_qv_reg) * PW'(side_h);
        ic    = pc[PW-1:32];
        ir    = pr[PW-1:32];
        lim_w = side_w - SIDE_BITS'(1);
        lim_h = side_h - SIDE_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sc_v_reg <= 1'b0;
        else
            sc_v_reg <= ce_v_reg;
    end

    always_ff @(posedge clk)
    begin
        sc_it_reg  <= ce_it_reg;
        sc_col_reg <= (ic > (PW-32)'(lim_w)) ? COORD_BITS'(lim_w) : COORD_BITS'(ic);
        sc_row_reg <= (ir > (PW-32)'(lim_h)) ? COORD_BITS'(lim_h) : COORD_BITS'(ir);
    end

    // Texel index row * width + column.
    logic [COORD_BITS+SIDE_BITS-1:0] lin;
    coord_t                          out_reg;
    logic                            out_v_reg;

    assign lin = (COORD_BITS+SIDE_BITS)'(sc_row_reg) * (COORD_BITS+SIDE_BITS)'(side_w)
               + (COORD_BITS+SIDE_BITS)'(sc_col_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else
            out_v_reg <= sc_v_reg;
    end

    always_ff @(posedge clk)
    begin
        out_reg.valid <= 1'b1;
        out_reg.item  <= sc_it_reg;
        out_reg.col   <= sc_col_reg;
        out_reg.row   <= sc_row_reg;
        out_reg.index <= lin[ADDR_BITS-1:0];
    end

    always_comb
    begin
        out_word       = out_reg;
        out_word.valid = out_v_reg;
    end

endmodule

`default_nettype wire

// ===== src/angular_map_environment_lookup.sv =====
// Top level of the angular environment map lookup with its texel store.
//
// Commands enter on start while busy is low; busy is never raised, so one
// word can be accepted in every clock cycle. A write word (opcode 0) stores
// one RGB texel at texel_address; a lookup word (opcode 1) maps dir_x/y/z
// through the angular projection and returns the texel with its column
// and row. Both kinds travel the same pipeline, so texel writes and reads
// keep their command order.
// A lookup result is shown on the result ports for one cycle, marked by
// result_valid. The pipeline holds the 32 square-root stages, 30 CORDIC
// stages and 32 divider stages, plus setup, scaling and the registered
// store read. A write gives no result.
// The receiver cannot stall; results are simply presented.
// Map width and height are written through the cfg port, which is always
// ready; write them only while no command is in flight.
// Reset clears the pipeline valid bits and sets both sides to 256; the
// texel store is not cleared and must be written before it is read.
`default_nettype none

module angular_map_environment_lookup
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    output      logic                                 busy,
    input  wire logic                                 opcode,
    input  wire logic [amel_pkg::ADDR_BITS-1:0]       texel_address,
    input  wire logic [amel_pkg::CHANNEL_BITS-1:0]    texel_red,
    input  wire logic [amel_pkg::CHANNEL_BITS-1:0]    texel_green,
    input  wire logic [amel_pkg::CHANNEL_BITS-1:0]    texel_blue,
    input  wire logic signed [amel_pkg::DIR_BITS-1:0] dir_x,
    input  wire logic signed [amel_pkg::DIR_BITS-1:0] dir_y,
    input  wire logic signed [amel_pkg::DIR_BITS-1:0] dir_z,
    input  wire logic                                 cfg_valid,
    output      logic                                 cfg_ready,
    input  wire logic                                 cfg_index,
    input  wire logic [amel_pkg::SIDE_BITS-1:0]       cfg_data,
    output      logic                                 result_valid,
    output      logic [amel_pkg::CHANNEL_BITS-1:0]    out_red,
    output      logic [amel_pkg::CHANNEL_BITS-1:0]    out_green,
    output      logic [amel_pkg::CHANNEL_BITS-1:0]    out_blue,
    output      logic [amel_pkg::COORD_BITS-1:0]      map_column,
    output      logic [amel_pkg::COORD_BITS-1:0]      map_row
);
    import amel_pkg::*;

    // Handshakes: the block never holds off either channel.
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Configuration registers.
    logic [SIDE_BITS-1:0] map_width_reg, map_height_reg;
    logic [SIDE_BITS-1:0] side_w, side_h;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg  <= SIDE_BITS'(MAX_SIDE);
            map_height_reg <= SIDE_BITS'(MAX_SIDE);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MAP_WIDTH:  map_width_reg  <= cfg_data;
                REG_MAP_HEIGHT: map_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign side_w = side_of(map_width_reg);
    assign side_h = side_of(map_height_reg);

    // Coordinate pipeline.
    item_t  in_item;
    coord_t cw;

    always_comb
    begin
        in_item.opcode = op_t'(opcode);
        in_item.addr   = texel_address;
        in_item.red    = texel_red;
        in_item.green  = texel_green;
        in_item.blue   = texel_blue;
    end

    amel_coord u_coord
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start && !busy),
        .in_item  (in_item),
        .dir_x    (dir_x),
        .dir_y    (dir_y),
        .dir_z    (dir_z),
        .side_w   (side_w),
        .side_h   (side_h),
        .out_word (cw)
    );

    // Texel store: writes and reads in command order, read data registered.
    logic [TEXEL_BITS-1:0]  texel_mem [0:STORE_DEPTH-1];
    logic [TEXEL_BITS-1:0]  rd_reg;
    logic [COORD_BITS-1:0]  col_reg, row_reg;
    logic                   res_v_reg;

    always_ff @(posedge clk)
    begin
        if (cw.valid && (cw.item.opcode == OP_WRITE))
            texel_mem[cw.item.addr] <= {cw.item.red, cw.item.green, cw.item.blue};
        rd_reg  <= texel_mem[cw.index];
        col_reg <= cw.col;
        row_reg <= cw.row;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_v_reg <= 1'b0;
        else
            res_v_reg <= cw.valid && (cw.item.opcode == OP_LOOKUP);
    end

    assign result_valid = res_v_reg;
    assign out_red      = rd_reg[3*CHANNEL_BITS-1:2*CHANNEL_BITS];
    assign out_green    = rd_reg[2*CHANNEL_BITS-1:CHANNEL_BITS];
    assign out_blue     = rd_reg[CHANNEL_BITS-1:0];
    assign map_column   = col_reg;
    assign map_row      = row_reg;

    // The chosen column and row always lie inside the map in use.
    a_col_in_map: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ({1'b0, map_column} < side_w))
        else $error("map column outside the map");

    a_row_in_map: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ({1'b0, map_row} < side_h))
        else $error("map row outside the map");

    // A texel write never produces a result word.
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (cw.valid && (cw.item.opcode == OP_WRITE)) |=> !result_valid)
        else $error("result word from a texel write");

endmodule

`default_nettype wire
